[rtl/owts_pkg.sv]
// Shared codes and constants for the 1-Wire thermometer sequencer.
// Holds sequencer state codes, bus command codes and the CRC-8 update.
// No dependencies.
package owts_pkg;

  // Item opcodes
  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_ROM_REQ = 2'd2;

  // Bus commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_XCHG  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_WAIT_SECONDS = 2'd0;
  localparam logic [1:0] REG_RESOLUTION   = 2'd1;
  localparam logic [1:0] REG_TEMP_ERR_LIM = 2'd2;
  localparam logic [1:0] REG_ROM_RETRY    = 2'd3;

  // Sensor command bytes
  localparam logic [7:0] BYTE_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] BYTE_WRITE_PAD = 8'h4E;
  localparam logic [7:0] BYTE_CONVERT   = 8'h44;
  localparam logic [7:0] BYTE_READ_PAD  = 8'hBE;
  localparam logic [7:0] BYTE_READ_ROM  = 8'h33;
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] POR_MSB        = 8'h05;
  localparam logic [7:0] POR_LSB        = 8'h50;
  localparam logic [7:0] TEMP_UNKNOWN   = 8'h7F;
  localparam logic [15:0] LOG_UNKNOWN   = 16'h07FF;
  localparam logic [7:0] CRC_POLY       = 8'h8C;

  // ROM code geometry
  localparam int unsigned ROM_BYTES = 8;
  localparam int unsigned ROM_IDX_W = $clog2(ROM_BYTES);
  localparam logic [ROM_IDX_W-1:0] ROM_LAST_IDX = ROM_IDX_W'(ROM_BYTES - 1);

  // Sequencer state codes
  localparam logic [7:0] ST_CFG_RESET = 8'h01;
  localparam logic [7:0] ST_CFG_SKIP  = 8'h02;
  localparam logic [7:0] ST_CFG_WRPAD = 8'h03;
  localparam logic [7:0] ST_CFG_TH    = 8'h04;
  localparam logic [7:0] ST_CFG_TL    = 8'h05;
  localparam logic [7:0] ST_CFG_RES   = 8'h06;
  localparam logic [7:0] ST_WAIT      = 8'h11;
  localparam logic [7:0] ST_CNV_RESET = 8'h21;
  localparam logic [7:0] ST_CNV_SKIP  = 8'h22;
  localparam logic [7:0] ST_CNV_CMD   = 8'h23;
  localparam logic [7:0] ST_POLL_TX   = 8'h31;
  localparam logic [7:0] ST_POLL_RX   = 8'h32;
  localparam logic [7:0] ST_RD_RESET  = 8'h41;
  localparam logic [7:0] ST_RD_SKIP   = 8'h42;
  localparam logic [7:0] ST_RD_CMD    = 8'h43;
  localparam logic [7:0] ST_RD_FIRST  = 8'h44;
  localparam logic [7:0] ST_RD_LSB    = 8'h45;
  localparam logic [7:0] ST_RD_MSB    = 8'h46;
  localparam logic [7:0] ST_RD_LAST   = 8'h4C;
  localparam logic [7:0] ST_RD_CRC    = 8'h4D;
  localparam logic [7:0] ST_EVAL      = 8'h61;
  localparam logic [7:0] ST_DONE_OK   = 8'h71;
  localparam logic [7:0] ST_DONE_ERR  = 8'h81;
  localparam logic [7:0] ST_ROM_INIT  = 8'h90;
  localparam logic [7:0] ST_ROM_RESET = 8'h91;
  localparam logic [7:0] ST_ROM_CMD   = 8'h92;
  localparam logic [7:0] ST_ROM_FIRST = 8'h93;
  localparam logic [7:0] ST_ROM_DATA  = 8'h94;
  localparam logic [7:0] ST_ROM_CRC   = 8'h95;

  // Reflected CRC-8 update over one byte, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ data[i];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

[rtl/onewire_temp_sensor_sequencer_top.sv]
// Top level of the 1-Wire thermometer byte sequencer.
// Input item register, one-step sequencer logic, result register.
// Depends on owts_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: opcode_i and
//   rx_byte_i. Opcode step advances the sequencer with the byte received by
//   the last bus exchange, tick counts one second, rom request schedules a
//   ROM code read. Every item gives exactly one result item on the output
//   channel (out_valid_o / out_stall_i): the next bus command and status.
//   The item waits in the input register, and its result is captured in the
//   result register when it advances. One item is taken every cycle while the
//   receiver does not stall; the state update is combinational and includes a
//   full byte of the CRC-8 unrolled in logic.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; after that in_stall_o rises.
//   Configuration (cfg_valid_i / cfg_ready_o) is always ready; the user must
//   write it only while the block is idle. The block itself does not enforce this.
//   Reset puts the sequencer at the start of sensor configuration with the
//   temperature unknown and the ROM code not ready.
module onewire_temp_sensor_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  bus_cmd_o,
  output logic [7:0]  tx_byte_o,
  output logic signed [7:0] temperature_o,
  output logic [7:0]  raw_msb_o,
  output logic [7:0]  raw_lsb_o,
  output logic        crc_error_o,
  output logic        rom_ready_o,
  output logic        rom_fail_o,
  output logic [owts_pkg::ROM_BYTES*8-1:0] rom_code_o,
  output logic [7:0]  phase_o,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import owts_pkg::*;

  // Configuration registers
  logic [7:0] wait_seconds_q, resolution_q;
  logic [2:0] temp_err_lim_q, rom_retry_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_seconds_q  <= 8'd5;
      resolution_q    <= 8'h7F;
      temp_err_lim_q  <= 3'd3;
      rom_retry_lim_q <= 3'd5;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WAIT_SECONDS: wait_seconds_q  <= cfg_data_i;
        REG_RESOLUTION:   resolution_q    <= cfg_data_i;
        REG_TEMP_ERR_LIM: temp_err_lim_q  <= cfg_data_i[2:0];
        REG_ROM_RETRY:    rom_retry_lim_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic in_vld_q, out_vld_q;
  logic in_acc, advance;

  assign in_stall_o = in_vld_q & out_vld_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign advance    = in_vld_q & ~(out_vld_q & out_stall_i);

  // Input item register
  logic [1:0] op_q;
  logic [7:0] rx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= opcode_i;
      rx_q <= rx_byte_i;
    end
  end

  // Sequencer state
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  tlo_q, tlo_d, thi_q, thi_d;
  logic        crc_fail_q, crc_fail_d;
  logic [2:0]  fail_cnt_q, fail_cnt_d;
  logic [7:0]  wait_cnt_q, wait_cnt_d;
  logic [ROM_IDX_W-1:0] rom_idx_q, rom_idx_d;
  logic        rom_req_q, rom_req_d;
  logic [2:0]  rom_retries_q, rom_retries_d;
  logic        done_rdy_q, done_rdy_d, done_fail_q, done_fail_d;
  logic [7:0]  temp_value_q, temp_value_d;
  logic [15:0] logged_q, logged_d;
  logic [7:0]  rom_store_q [ROM_BYTES];
  logic [7:0]  rom_store_d [ROM_BYTES];
  logic        rom_wr;
  logic [1:0]  cmd;
  logic [7:0]  tx;
  logic [7:0]  crc_upd;
  logic [2:0]  fail_inc, retry_inc;
  logic [ROM_IDX_W-1:0] rom_idx_inc;
  logic [ROM_BYTES*8-1:0] rom_code;

  assign crc_upd     = crc8_byte(crc_q, rx_q);
  assign fail_inc    = fail_cnt_q + 3'd1;
  assign retry_inc   = rom_retries_q + 3'd1;
  assign rom_idx_inc = rom_idx_q + ROM_IDX_W'(1);

  // One update per item: a sequencer step, a tick or a ROM request
  always_comb begin
    seq_d         = seq_q;
    crc_d         = crc_q;
    tlo_d         = tlo_q;
    thi_d         = thi_q;
    crc_fail_d    = crc_fail_q;
    fail_cnt_d    = fail_cnt_q;
    wait_cnt_d    = wait_cnt_q;
    rom_idx_d     = rom_idx_q;
    rom_req_d     = rom_req_q;
    rom_retries_d = rom_retries_q;
    done_rdy_d    = done_rdy_q;
    done_fail_d   = done_fail_q;
    temp_value_d  = temp_value_q;
    logged_d      = logged_q;
    rom_wr        = 1'b0;
    cmd           = CMD_NONE;
    tx            = 8'h00;

    case (op_q)
      OP_STEP: begin
        case (seq_q)
          ST_CFG_RESET: begin seq_d = ST_CFG_SKIP; cmd = CMD_RESET; end
          ST_CFG_SKIP: begin
            seq_d = ST_CFG_WRPAD; cmd = CMD_XCHG; tx = BYTE_SKIP_ROM;
          end
          ST_CFG_WRPAD: begin
            seq_d = ST_CFG_TH; cmd = CMD_XCHG; tx = BYTE_WRITE_PAD;
          end
          ST_CFG_TH, ST_CFG_TL: begin
            seq_d = seq_q + 8'd1; cmd = CMD_XCHG; tx = BYTE_IDLE;
          end
          ST_CFG_RES: begin
            seq_d = ST_WAIT; cmd = CMD_XCHG; tx = resolution_q;
            wait_cnt_d = 8'd0;
          end
          ST_WAIT: begin
            if (wait_cnt_q >= wait_seconds_q) seq_d = ST_CNV_RESET;
          end
          ST_CNV_RESET: begin seq_d = ST_CNV_SKIP; cmd = CMD_RESET; end
          ST_CNV_SKIP: begin
            seq_d = ST_CNV_CMD; cmd = CMD_XCHG; tx = BYTE_SKIP_ROM;
          end
          ST_CNV_CMD: begin
            seq_d = ST_POLL_TX; cmd = CMD_XCHG; tx = BYTE_CONVERT;
          end
          ST_POLL_TX: begin
            seq_d = ST_POLL_RX; cmd = CMD_XCHG; tx = BYTE_IDLE;
          end
          ST_POLL_RX: begin
            seq_d = (rx_q == BYTE_IDLE) ? ST_RD_RESET : ST_POLL_TX;
          end
          ST_RD_RESET: begin
            crc_fail_d = 1'b0; seq_d = ST_RD_SKIP; cmd = CMD_RESET;
          end
          ST_RD_SKIP: begin
            seq_d = ST_RD_CMD; cmd = CMD_XCHG; tx = BYTE_SKIP_ROM;
          end
          ST_RD_CMD: begin
            seq_d = ST_RD_FIRST; cmd = CMD_XCHG; tx = BYTE_READ_PAD;
          end
          ST_RD_FIRST: begin
            crc_d = 8'h00; seq_d = ST_RD_LSB; cmd = CMD_XCHG; tx = BYTE_IDLE;
          end
          ST_RD_CRC: begin
            if (crc_q != rx_q) crc_fail_d = 1'b1;
            seq_d = ST_EVAL;
          end
          ST_EVAL: begin
            if (crc_fail_q) begin
              fail_cnt_d = fail_inc;
              if (fail_inc >= temp_err_lim_q) begin
                fail_cnt_d   = 3'd0;
                temp_value_d = TEMP_UNKNOWN;
                logged_d     = LOG_UNKNOWN;
              end
              seq_d = rom_req_q ? ST_ROM_INIT : ST_DONE_ERR;
            end else begin
              if (thi_q == POR_MSB && tlo_q == POR_LSB) begin
                temp_value_d = TEMP_UNKNOWN;
                logged_d     = LOG_UNKNOWN;
              end else begin
                temp_value_d = {thi_q[3:0], tlo_q[7:4]};
                logged_d     = {thi_q, tlo_q};
              end
              seq_d = rom_req_q ? ST_ROM_INIT : ST_DONE_OK;
            end
          end
          ST_DONE_OK, ST_DONE_ERR: begin
            seq_d = ST_CFG_RESET; cmd = CMD_RESET;
          end
          ST_ROM_INIT: begin
            rom_req_d     = 1'b0;
            done_fail_d   = 1'b0;
            rom_retries_d = 3'd0;
            seq_d         = ST_ROM_RESET;
          end
          ST_ROM_RESET: begin seq_d = ST_ROM_CMD; cmd = CMD_RESET; end
          ST_ROM_CMD: begin
            seq_d = ST_ROM_FIRST; cmd = CMD_XCHG; tx = BYTE_READ_ROM;
          end
          ST_ROM_FIRST: begin
            crc_d = 8'h00; rom_idx_d = '0;
            seq_d = ST_ROM_DATA; cmd = CMD_XCHG; tx = BYTE_IDLE;
          end
          ST_ROM_DATA: begin
            crc_d     = crc_upd;
            rom_wr    = 1'b1;
            rom_idx_d = rom_idx_inc;
            if (rom_idx_inc == ROM_LAST_IDX) seq_d = ST_ROM_CRC;
            cmd = CMD_XCHG; tx = BYTE_IDLE;
          end
          ST_ROM_CRC: begin
            rom_wr = 1'b1;
            if (crc_q != rx_q) begin
              rom_retries_d = retry_inc;
              if (retry_inc >= rom_retry_lim_q) begin
                done_rdy_d  = 1'b1;
                done_fail_d = 1'b1;
                seq_d       = ST_DONE_ERR;
              end else begin
                seq_d = ST_ROM_RESET;
              end
            end else begin
              done_rdy_d = 1'b1;
              seq_d      = ST_DONE_OK;
            end
          end
          default: begin
            // Scratchpad data bytes share one arm; anything else restarts
            if (seq_q inside {[ST_RD_LSB:ST_RD_LAST]}) begin
              crc_d = crc_upd;
              if (seq_q == ST_RD_LSB) tlo_d = rx_q;
              if (seq_q == ST_RD_MSB) thi_d = rx_q;
              seq_d = seq_q + 8'd1; cmd = CMD_XCHG; tx = BYTE_IDLE;
            end else begin
              seq_d = ST_CFG_RESET;
            end
          end
        endcase
      end
      OP_TICK: begin
        if (wait_cnt_q != 8'hFF) wait_cnt_d = wait_cnt_q + 8'd1;
      end
      OP_ROM_REQ: begin
        rom_req_d   = 1'b1;
        done_rdy_d  = 1'b0;
        done_fail_d = 1'b0;
      end
      default: ;
    endcase
  end

  // ROM byte store with the current write folded in
  always_comb begin
    for (int i = 0; i < ROM_BYTES; i++) begin
      rom_store_d[i] = rom_store_q[i];
    end
    if (rom_wr) rom_store_d[rom_idx_q] = rx_q;
    for (int i = 0; i < ROM_BYTES; i++) begin
      rom_code[i*8 +: 8] = rom_store_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && rom_wr) begin
      rom_store_q[rom_idx_q] <= rx_q;
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= ST_CFG_RESET;
      crc_q         <= 8'h00;
      tlo_q         <= 8'hFF;
      thi_q         <= 8'hFF;
      crc_fail_q    <= 1'b0;
      fail_cnt_q    <= 3'd0;
      wait_cnt_q    <= 8'd0;
      rom_idx_q     <= '0;
      rom_req_q     <= 1'b0;
      rom_retries_q <= 3'd0;
      done_rdy_q    <= 1'b0;
      done_fail_q   <= 1'b0;
      temp_value_q  <= TEMP_UNKNOWN;
      logged_q      <= LOG_UNKNOWN;
    end else if (advance) begin
      seq_q         <= seq_d;
      crc_q         <= crc_d;
      tlo_q         <= tlo_d;
      thi_q         <= thi_d;
      crc_fail_q    <= crc_fail_d;
      fail_cnt_q    <= fail_cnt_d;
      wait_cnt_q    <= wait_cnt_d;
      rom_idx_q     <= rom_idx_d;
      rom_req_q     <= rom_req_d;
      rom_retries_q <= rom_retries_d;
      done_rdy_q    <= done_rdy_d;
      done_fail_q   <= done_fail_d;
      temp_value_q  <= temp_value_d;
      logged_q      <= logged_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bus_cmd_o     <= cmd;
      tx_byte_o     <= tx;
      temperature_o <= temp_value_d;
      raw_msb_o     <= logged_d[15:8];
      raw_lsb_o     <= logged_d[7:0];
      crc_error_o   <= crc_fail_d;
      rom_ready_o   <= done_rdy_d;
      rom_fail_o    <= done_fail_d;
      rom_code_o    <= done_rdy_d ? rom_code : '0;
      phase_o       <= seq_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with empty input register");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result lost after step");

  a_fail_implies_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fail_q |-> done_rdy_q)
    else $error("rom fail flag set without ready");

  a_temp_matches_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    temp_value_q == logged_q[11:4])
    else $error("temperature out of step with raw bytes");

  a_rom_crc_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == ST_ROM_CRC |-> rom_idx_q == ROM_LAST_IDX)
    else $error("rom crc byte at wrong index");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the 1-Wire thermometer byte sequencer.
// Holds a step-accurate predictor and scoreboard, random stimulus and idling.
// Depends on owts_pkg and onewire_temp_sensor_sequencer_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import owts_pkg::*;

  // Opcode with no function; the block must report status only
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;

  // One result item, in port order
  typedef struct packed {
    logic [1:0]  bus_cmd;
    logic [7:0]  tx_byte;
    logic [7:0]  temperature;
    logic [7:0]  raw_msb;
    logic [7:0]  raw_lsb;
    logic        crc_error;
    logic        rom_ready;
    logic        rom_fail;
    logic [63:0] rom_code;
    logic [7:0]  phase;
  } bus_step_t;

  // Predicts the sequencer item by item and checks results in order
  class sequencer_scoreboard;
    logic [7:0]  wait_secs, res_code;
    logic [2:0]  temp_err_lim, rom_retry_lim;
    logic [7:0]  seq_st, crc_acc, temp_lsb, temp_msb, wait_cnt, temp_deg;
    logic [15:0] logged_raw;
    logic        crc_bad, rom_pending, rom_ready, rom_failed;
    logic [2:0]  fail_cnt, rom_idx, rom_tries;
    logic [7:0]  rom_bytes [8];
    bus_step_t   expected_steps [$];
    int unsigned items_seen, results_checked, errors;
    int unsigned pad_reads, pad_crc_bad, rom_reads;

    function new();
      wait_secs = 8'd5;
      res_code = 8'h7F;
      temp_err_lim = 3'd3;
      rom_retry_lim = 3'd5;
      seq_st = ST_CFG_RESET;
      crc_acc = 8'h00;
      temp_lsb = 8'hFF;
      temp_msb = 8'hFF;
      wait_cnt = 8'h00;
      temp_deg = TEMP_UNKNOWN;
      logged_raw = LOG_UNKNOWN;
      crc_bad = 1'b0;
      rom_pending = 1'b0;
      rom_ready = 1'b0;
      rom_failed = 1'b0;
      fail_cnt = 3'd0;
      rom_idx = 3'd0;
      rom_tries = 3'd0;
      foreach (rom_bytes[i]) rom_bytes[i] = 8'h00;
      items_seen = 0;
      results_checked = 0;
      errors = 0;
      pad_reads = 0;
      pad_crc_bad = 0;
      rom_reads = 0;
    endfunction

    function void load_reg(input logic [1:0] idx, input logic [7:0] data);
      case (idx)
        REG_WAIT_SECONDS: wait_secs = data;
        REG_RESOLUTION:   res_code = data;
        REG_TEMP_ERR_LIM: temp_err_lim = data[2:0];
        REG_ROM_RETRY:    rom_retry_lim = data[2:0];
        default: ;
      endcase
    endfunction

    // Reflected CRC-8, byte folded in first, then shifted out LSB first
    function logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void mark_unknown();
      temp_deg = TEMP_UNKNOWN;
      logged_raw = LOG_UNKNOWN;
    endfunction

    // One sequencer step on the byte from the last exchange
    function void seq_step(input logic [7:0] rx, output logic [1:0] cmd,
                           output logic [7:0] tx);
      cmd = CMD_NONE;
      tx = 8'h00;
      case (seq_st)
        ST_CFG_RESET: begin seq_st = ST_CFG_SKIP; cmd = CMD_RESET; end
        ST_CFG_SKIP: begin
          seq_st = ST_CFG_WRPAD; cmd = CMD_XCHG; tx = BYTE_SKIP_ROM;
        end
        ST_CFG_WRPAD: begin
          seq_st = ST_CFG_TH; cmd = CMD_XCHG; tx = BYTE_WRITE_PAD;
        end
        ST_CFG_TH, ST_CFG_TL: begin
          seq_st = seq_st + 8'd1; cmd = CMD_XCHG; tx = BYTE_IDLE;
        end
        ST_CFG_RES: begin
          seq_st = ST_WAIT; cmd = CMD_XCHG; tx = res_code;
          wait_cnt = 8'h00;
        end
        ST_WAIT: if (wait_cnt >= wait_secs) seq_st = ST_CNV_RESET;
        ST_CNV_RESET: begin seq_st = ST_CNV_SKIP; cmd = CMD_RESET; end
        ST_CNV_SKIP: begin
          seq_st = ST_CNV_CMD; cmd = CMD_XCHG; tx = BYTE_SKIP_ROM;
        end
        ST_CNV_CMD: begin
          seq_st = ST_POLL_TX; cmd = CMD_XCHG; tx = BYTE_CONVERT;
        end
        ST_POLL_TX: begin seq_st = ST_POLL_RX; cmd = CMD_XCHG; tx = BYTE_IDLE; end
        ST_POLL_RX: seq_st = (rx == BYTE_IDLE) ? ST_RD_RESET : ST_POLL_TX;
        ST_RD_RESET: begin crc_bad = 1'b0; seq_st = ST_RD_SKIP; cmd = CMD_RESET; end
        ST_RD_SKIP: begin
          seq_st = ST_RD_CMD; cmd = CMD_XCHG; tx = BYTE_SKIP_ROM;
        end
        ST_RD_CMD: begin
          seq_st = ST_RD_FIRST; cmd = CMD_XCHG; tx = BYTE_READ_PAD;
        end
        ST_RD_FIRST: begin
          crc_acc = 8'h00; seq_st = ST_RD_LSB; cmd = CMD_XCHG; tx = BYTE_IDLE;
        end
        ST_RD_CRC: begin
          if (crc_acc != rx) crc_bad = 1'b1;
          seq_st = ST_EVAL;
        end
        // Accept the reading, or count a failed read
        ST_EVAL: begin
          pad_reads++;
          if (crc_bad) begin
            pad_crc_bad++;
            fail_cnt = fail_cnt + 3'd1;
            if (fail_cnt >= temp_err_lim) begin
              fail_cnt = 3'd0;
              mark_unknown();
            end
            seq_st = rom_pending ? ST_ROM_INIT : ST_DONE_ERR;
          end else begin
            if (temp_msb == POR_MSB && temp_lsb == POR_LSB) begin
              mark_unknown();
            end else begin
              temp_deg = {temp_msb[3:0], temp_lsb[7:4]};
              logged_raw = {temp_msb, temp_lsb};
            end
            seq_st = rom_pending ? ST_ROM_INIT : ST_DONE_OK;
          end
        end
        ST_DONE_OK, ST_DONE_ERR: begin seq_st = ST_CFG_RESET; cmd = CMD_RESET; end
        ST_ROM_INIT: begin
          rom_pending = 1'b0; rom_failed = 1'b0; rom_tries = 3'd0;
          seq_st = ST_ROM_RESET;
        end
        ST_ROM_RESET: begin seq_st = ST_ROM_CMD; cmd = CMD_RESET; end
        ST_ROM_CMD: begin
          seq_st = ST_ROM_FIRST; cmd = CMD_XCHG; tx = BYTE_READ_ROM;
        end
        ST_ROM_FIRST: begin
          crc_acc = 8'h00; rom_idx = 3'd0;
          seq_st = ST_ROM_DATA; cmd = CMD_XCHG; tx = BYTE_IDLE;
        end
        ST_ROM_DATA: begin
          crc_acc = crc_next(crc_acc, rx);
          rom_bytes[rom_idx] = rx;
          rom_idx = rom_idx + 3'd1;
          if (rom_idx == 3'd7) seq_st = ST_ROM_CRC;
          cmd = CMD_XCHG; tx = BYTE_IDLE;
        end
        // Last ROM byte is the CRC; retry the read until the limit
        ST_ROM_CRC: begin
          rom_bytes[rom_idx] = rx;
          if (crc_acc != rx) begin
            rom_tries = rom_tries + 3'd1;
            if (rom_tries >= rom_retry_lim) begin
              rom_ready = 1'b1; rom_failed = 1'b1;
              seq_st = ST_DONE_ERR;
              rom_reads++;
            end else begin
              seq_st = ST_ROM_RESET;
            end
          end else begin
            rom_ready = 1'b1;
            seq_st = ST_DONE_OK;
            rom_reads++;
          end
        end
        default: begin
          // Scratchpad data bytes; the first two hold the raw temperature
          if (seq_st >= ST_RD_LSB && seq_st <= ST_RD_LAST) begin
            crc_acc = crc_next(crc_acc, rx);
            if (seq_st == ST_RD_LSB) temp_lsb = rx;
            if (seq_st == ST_RD_MSB) temp_msb = rx;
            seq_st = seq_st + 8'd1; cmd = CMD_XCHG; tx = BYTE_IDLE;
          end else begin
            seq_st = ST_CFG_RESET;
          end
        end
      endcase
    endfunction

    // Accepted input item: advance the predictor, queue the expected result
    function void take_item(input logic [1:0] op, input logic [7:0] rx);
      bus_step_t r;
      r = '0;
      items_seen++;
      case (op)
        OP_STEP: seq_step(rx, r.bus_cmd, r.tx_byte);
        OP_TICK: if (wait_cnt != 8'hFF) wait_cnt = wait_cnt + 8'd1;
        OP_ROM_REQ: begin rom_pending = 1'b1; rom_ready = 1'b0; rom_failed = 1'b0; end
        default: ;
      endcase
      r.temperature = temp_deg;
      r.raw_msb = logged_raw[15:8];
      r.raw_lsb = logged_raw[7:0];
      r.crc_error = crc_bad;
      r.rom_ready = rom_ready;
      r.rom_fail = rom_failed;
      if (rom_ready) foreach (rom_bytes[i]) r.rom_code[8*i +: 8] = rom_bytes[i];
      r.phase = seq_st;
      expected_steps.push_back(r);
    endfunction

    function void field_check(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    // Accepted result item: compare with the oldest expectation
    function void check_step(input bus_step_t got);
      bus_step_t want;
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected, phase %0h", $time, got.phase);
        return;
      end
      want = expected_steps.pop_front();
      results_checked++;
      field_check("bus_cmd", want.bus_cmd, got.bus_cmd);
      field_check("tx_byte", want.tx_byte, got.tx_byte);
      field_check("temperature", want.temperature, got.temperature);
      field_check("raw_msb", want.raw_msb, got.raw_msb);
      field_check("raw_lsb", want.raw_lsb, got.raw_lsb);
      field_check("crc_error", want.crc_error, got.crc_error);
      field_check("rom_ready", want.rom_ready, got.rom_ready);
      field_check("rom_fail", want.rom_fail, got.rom_fail);
      field_check("rom_code", want.rom_code, got.rom_code);
      field_check("phase", want.phase, got.phase);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  bus_cmd_o;
  logic [7:0]  tx_byte_o;
  logic signed [7:0] temperature_o;
  logic [7:0]  raw_msb_o;
  logic [7:0]  raw_lsb_o;
  logic        crc_error_o;
  logic        rom_ready_o;
  logic        rom_fail_o;
  logic [ROM_BYTES*8-1:0] rom_code_o;
  logic [7:0]  phase_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  sequencer_scoreboard book;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  onewire_temp_sensor_sequencer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bus_cmd_o     (bus_cmd_o),
    .tx_byte_o     (tx_byte_o),
    .temperature_o (temperature_o),
    .raw_msb_o     (raw_msb_o),
    .raw_lsb_o     (raw_lsb_o),
    .crc_error_o   (crc_error_o),
    .rom_ready_o   (rom_ready_o),
    .rom_fail_o    (rom_fail_o),
    .rom_code_o    (rom_code_o),
    .phase_o       (phase_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i)
        book.check_step({bus_cmd_o, tx_byte_o, temperature_o, raw_msb_o, raw_lsb_o,
                         crc_error_o, rom_ready_o, rom_fail_o, rom_code_o, phase_o});
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no item moving on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one input item after a random gap, wait for it to be taken
  task automatic push_item(input logic [1:0] op, input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    rx_byte_i <= rx;
    do @(posedge clk_i); while (in_stall_o);
    book.take_item(op, rx);
  endtask

  // Register write; the caller drops cfg_valid_i after the last one
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    book.load_reg(idx, data);
  endtask

  // Mostly well-formed bus replies for the current state, some noise
  function automatic void choose_item(output logic [1:0] op, output logic [7:0] rx);
    int unsigned roll;
    roll = $urandom_range(99);
    op = OP_STEP;
    rx = 8'($urandom);
    if (roll < 3) begin
      op = OP_ROM_REQ;
    end else if (roll < 5) begin
      op = OP_UNUSED;
    end else if (roll < 12) begin
      op = OP_TICK;
    end else if (roll >= 17) begin
      case (book.seq_st)
        ST_WAIT: if (book.wait_cnt < book.wait_secs) op = OP_TICK;
        ST_POLL_RX: if ($urandom_range(99) < 60) rx = BYTE_IDLE;
        ST_RD_LSB: if ($urandom_range(99) < 20) rx = POR_LSB;
        ST_RD_MSB: if (book.temp_lsb == POR_LSB && $urandom_range(99) < 60) rx = POR_MSB;
        ST_RD_CRC, ST_ROM_CRC: if ($urandom_range(99) < 75) rx = book.crc_acc;
        default: ;
      endcase
    end
  endfunction

  // One register setting with its idling mix and its items
  task automatic run_phase(input int unsigned idx);
    logic [7:0]  w, r, t, m;
    int unsigned n;
    logic [1:0]  op;
    logic [7:0]  rx;
    // registers change only with nothing in flight
    while (book.expected_steps.size() != 0) @(posedge clk_i);
    case (idx)
      0: begin
        w = 8'd0; r = 8'h1F; t = 8'h00; m = 8'hF8;
        send_idle_pct = 0; recv_stall_pct = 0; n = 60;
      end
      1: begin
        w = 8'd1; r = 8'h7F; t = 8'h07; m = 8'h07;
        send_idle_pct = 62; recv_stall_pct = 0; n = 80;
      end
      2: begin
        w = 8'hFF; r = 8'hFF; t = 8'h01; m = 8'h01;
        send_idle_pct = 0; recv_stall_pct = 62; n = 125;
      end
      3: begin
        w = 8'($urandom_range(4)); r = 8'($urandom); t = 8'($urandom); m = 8'($urandom);
        send_idle_pct = 15; recv_stall_pct = 15; n = 80;
      end
      default: begin
        w = 8'd2; r = 8'h00; t = 8'hFB; m = 8'h05;
        send_idle_pct = 0; recv_stall_pct = 0; n = 40;
      end
    endcase
    cfg_write(REG_WAIT_SECONDS, w);
    cfg_write(REG_RESOLUTION, r);
    cfg_write(REG_TEMP_ERR_LIM, t);
    cfg_write(REG_ROM_RETRY, m);
    cfg_valid_i <= 1'b0;
    if (idx == 0) begin
      // status-only opcodes, then one pass up to the scratchpad read
      push_item(OP_TICK, 8'h00);
      push_item(OP_UNUSED, 8'hFF);
      push_item(OP_ROM_REQ, 8'hA5);
      for (int k = 0; k < 6; k++) push_item(OP_STEP, k[0] ? 8'hFF : 8'h00);
      push_item(OP_STEP, 8'h5A);
      repeat (4) push_item(OP_STEP, 8'h00);
      push_item(OP_STEP, 8'h00);
      push_item(OP_STEP, 8'hFF);
      push_item(OP_STEP, 8'hFF);
    end
    repeat (n) begin
      choose_item(op, rx);
      push_item(op, rx);
    end
    in_valid_i <= 1'b0;
  endtask

  // Reset, register settings in turn, drain, verdict
  initial begin
    book = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i <= OP_STEP;
    rx_byte_i <= 8'h00;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_WAIT_SECONDS;
    cfg_data_i <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 5; p++) run_phase(p);
    while (book.expected_steps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Ran %0d items through five register settings, %0d results compared.",
             book.items_seen, book.results_checked);
    $display("Scratchpad reads %0d (%0d with bad crc), rom code reads finished %0d.",
             book.pad_reads, book.pad_crc_bad, book.rom_reads);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/owts_pkg.sv
rtl/onewire_temp_sensor_sequencer_top.sv
sim/testbench.sv
